@@ rtl/core/esd_pkg.sv @@
`timescale 1ns / 1ps

package esd_pkg;

    // Characters that matter to the decoder.
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
    localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_NINE      = 8'h39;
    localparam logic [7:0] CHAR_LOWER_X   = 8'h78;
    localparam logic [7:0] CHAR_UPPER_X   = 8'h58;
    localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
    localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F   = 8'h46;

    // Decoded values of the named escapes.
    localparam logic [7:0] CODE_LINE_FEED = 8'h0A;
    localparam logic [7:0] CODE_CARRIAGE  = 8'h0D;
    localparam logic [7:0] CODE_NUL       = 8'h00;

    typedef enum logic [1:0] {
        PHASE_PLAIN = 2'd0,
        PHASE_ESC   = 2'd1,
        PHASE_HEX1  = 2'd2,
        PHASE_HEX2  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } esd_in_t;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       done_res;
        logic       error;
    } esd_out_t;

    // Decoder state carried between the register stage and the decode logic.
    typedef struct packed {
        phase_t     phase;
        logic [3:0] hex_high;
    } esd_state_t;

    // Bit 4 is set when the character is not a hex digit; bits 3:0 hold its value.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] diff;
        begin
            diff = 8'h00;
            if (c >= CHAR_ZERO && c <= CHAR_NINE)
            begin
                diff = c - CHAR_ZERO;
                hex_value = {1'b0, diff[3:0]};
            end
            else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
            begin
                diff = c - CHAR_LOWER_A + 8'd10;
                hex_value = {1'b0, diff[3:0]};
            end
            else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
            begin
                diff = c - CHAR_UPPER_A + 8'd10;
                hex_value = {1'b0, diff[3:0]};
            end
            else
            begin
                hex_value = 5'b1_0000;
            end
        end
    endfunction

endpackage

@@ rtl/core/esd_decode.sv @@
`timescale 1ns / 1ps

// One decode step: from the current state and one raw byte, the result and the next state.
module esd_decode (
    input  esd_pkg::esd_state_t state,
    input  esd_pkg::esd_in_t    item,
    output esd_pkg::esd_state_t state_next,
    output esd_pkg::esd_out_t   result
);

    logic [4:0] hv;
    logic       is_hex;

    assign hv     = esd_pkg::hex_value(item.in_byte);
    assign is_hex = ~hv[4];

    // Next state.
    always_comb
    begin
        state_next = state;
        unique case (state.phase)
            esd_pkg::PHASE_PLAIN:
            begin
                if (item.in_byte == esd_pkg::CHAR_BACKSLASH)
                    state_next.phase = esd_pkg::PHASE_ESC;
            end
            esd_pkg::PHASE_ESC:
            begin
                if (item.in_byte == esd_pkg::CHAR_LOWER_X ||
                    item.in_byte == esd_pkg::CHAR_UPPER_X)
                    state_next.phase = esd_pkg::PHASE_HEX1;
                else
                    state_next.phase = esd_pkg::PHASE_PLAIN;
            end
            esd_pkg::PHASE_HEX1:
            begin
                if (is_hex)
                begin
                    state_next.phase    = esd_pkg::PHASE_HEX2;
                    state_next.hex_high = hv[3:0];
                end
                else
                begin
                    state_next.phase = esd_pkg::PHASE_PLAIN;
                end
            end
            esd_pkg::PHASE_HEX2:
            begin
                state_next.phase    = esd_pkg::PHASE_PLAIN;
                state_next.hex_high = 4'h0;
            end
            default:
            begin
                state_next.phase = esd_pkg::PHASE_PLAIN;
            end
        endcase
        // The last byte ends the literal and returns the decoder to reset.
        if (item.last_byte)
        begin
            state_next.phase    = esd_pkg::PHASE_PLAIN;
            state_next.hex_high = 4'h0;
        end
    end

    // Result.
    always_comb
    begin
        result           = '0;
        result.done_res  = item.last_byte;
        unique case (state.phase)
            esd_pkg::PHASE_PLAIN:
            begin
                if (item.in_byte == esd_pkg::CHAR_BACKSLASH)
                begin
                    result.error = item.last_byte;
                end
                else
                begin
                    result.out_valid = 1'b1;
                    result.out_byte  = item.in_byte;
                end
            end
            esd_pkg::PHASE_ESC:
            begin
                case (item.in_byte)
                    esd_pkg::CHAR_QUOTE, esd_pkg::CHAR_BACKSLASH:
                    begin
                        result.out_valid = 1'b1;
                        result.out_byte  = item.in_byte;
                    end
                    esd_pkg::CHAR_LOWER_N:
                    begin
                        result.out_valid = 1'b1;
                        result.out_byte  = esd_pkg::CODE_LINE_FEED;
                    end
                    esd_pkg::CHAR_LOWER_R:
                    begin
                        result.out_valid = 1'b1;
                        result.out_byte  = esd_pkg::CODE_CARRIAGE;
                    end
                    esd_pkg::CHAR_ZERO:
                    begin
                        result.out_valid = 1'b1;
                        result.out_byte  = esd_pkg::CODE_NUL;
                    end
                    default:
                    begin
                        result.out_valid = 1'b0;
                    end
                endcase
            end
            esd_pkg::PHASE_HEX1:
            begin
                // A single digit that ends the literal is emitted on its own.
                if (is_hex && item.last_byte)
                begin
                    result.out_valid = 1'b1;
                    result.out_byte  = {4'h0, hv[3:0]};
                end
            end
            esd_pkg::PHASE_HEX2:
            begin
                result.out_valid = 1'b1;
                if (is_hex)
                    result.out_byte = {state.hex_high, hv[3:0]};
                else
                    result.out_byte = {4'h0, state.hex_high};
            end
            default:
            begin
                result.out_valid = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/core/escape_sequence_decoder.sv @@
`timescale 1ns / 1ps

// String literal escape decoder.
//
// Requests arrive on req (raw byte plus a last-byte marker) under req_valid and
// req_stall; every accepted request yields exactly one result on rsp under
// rsp_valid and rsp_stall. A result may carry no character (out_valid low), for
// instance for a backslash or a dropped escape byte; done_res marks the result
// of the last byte, and error flags a literal that ends in a lone backslash.
//
// An accepted request lands in the input register; the decode logic then feeds
// the result register once that register is free, and the result is shown from
// there. Throughput is one request per cycle while the receiver does not stall;
// the decode phase and hex digit update in the same cycle that an item moves
// from the input register to the result register.
//
// When the receiver stalls, the result register holds its value and the input
// register keeps filling; req_stall rises only when both are full and rsp_stall
// is high. Reset clears both valid flags and returns the decoder to the plain
// character phase with a zero hex digit.
module escape_sequence_decoder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  esd_pkg::esd_in_t  req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output esd_pkg::esd_out_t rsp
);

    logic                in_valid_reg;
    esd_pkg::esd_in_t    in_data_reg;
    logic                out_valid_reg;
    esd_pkg::esd_out_t   out_data_reg;
    esd_pkg::esd_state_t state_reg;
    esd_pkg::esd_state_t state_next;
    esd_pkg::esd_out_t   result;

    logic out_free;
    logic advance;
    logic accept;

    // The result register can take a new value when empty or being drained.
    assign out_free  = ~out_valid_reg | ~rsp_stall;
    assign advance   = in_valid_reg & out_free;
    assign req_stall = in_valid_reg & ~out_free;
    assign accept    = req_valid & ~req_stall;

    esd_decode u_decode (
        .state      (state_reg),
        .item       (in_data_reg),
        .state_next (state_next),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            state_reg.phase    <= esd_pkg::PHASE_PLAIN;
            state_reg.hex_high <= 4'h0;
        end
        else
        begin
            // The input register empties when its item advances, refills on acceptance.
            if (accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (~rsp_stall)
                out_valid_reg <= 1'b0;

            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_data_reg <= req;
        if (advance)
            out_data_reg <= result;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

endmodule

@@ rtl/core/esd_checker.sv @@
`timescale 1ns / 1ps

module esd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_stall,
    input esd_pkg::esd_in_t  req,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input esd_pkg::esd_out_t rsp
);

    // A stalled result stays shown and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed or vanished");

    // A stalled request stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req))
    else $error("stalled request changed or vanished");

    // The request side only backs up when the result side is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
    else $error("request stalled without a held result");

    // An error only comes on the closing result and never with a character.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.error |-> rsp.done_res && !rsp.out_valid)
    else $error("error flag on a result that does not end the literal");

    // A result without a character carries a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.out_valid |-> rsp.out_byte == 8'h00)
    else $error("empty result carries a nonzero byte");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (.*);
